>>> rtl/core/ebalu_pkg.sv
// Shared operation codes, flag positions and request/response types for the eight-bit ALU.
package ebalu_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned DataW = 8;
  localparam int unsigned FlagW = 4;
  localparam int unsigned BitW  = 3;

  typedef logic [OpW-1:0]   op_t;
  typedef logic [DataW-1:0] byte_t;
  typedef logic [FlagW-1:0] flags_t;

  // Positions of the flags inside a flag nibble.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam op_t OpAdd  = 5'd0;
  localparam op_t OpAdc  = 5'd1;
  localparam op_t OpSub  = 5'd2;
  localparam op_t OpSbc  = 5'd3;
  localparam op_t OpAnd  = 5'd4;
  localparam op_t OpOr   = 5'd5;
  localparam op_t OpXor  = 5'd6;
  localparam op_t OpCp   = 5'd7;
  localparam op_t OpInc  = 5'd8;
  localparam op_t OpDec  = 5'd9;
  localparam op_t OpRlca = 5'd10;
  localparam op_t OpRla  = 5'd11;
  localparam op_t OpRrca = 5'd12;
  localparam op_t OpRra  = 5'd13;
  localparam op_t OpRlc  = 5'd14;
  localparam op_t OpRl   = 5'd15;
  localparam op_t OpRrc  = 5'd16;
  localparam op_t OpRr   = 5'd17;
  localparam op_t OpSla  = 5'd18;
  localparam op_t OpSra  = 5'd19;
  localparam op_t OpSrl  = 5'd20;
  localparam op_t OpSwap = 5'd21;
  localparam op_t OpBit  = 5'd22;
  localparam op_t OpSet  = 5'd23;
  localparam op_t OpRes  = 5'd24;
  localparam op_t OpDaa  = 5'd25;
  localparam op_t OpCpl  = 5'd26;
  localparam op_t OpCcf  = 5'd27;
  localparam op_t OpScf  = 5'd28;

  typedef struct packed {
    op_t                 operation;
    byte_t               acc_value;
    byte_t               operand;
    logic [BitW-1:0]     bit_index;
    flags_t              flags_in;
  } req_t;

  typedef struct packed {
    byte_t  result;
    flags_t flags_out;
  } rsp_t;

endpackage

>>> rtl/core/eight_bit_alu_with_flags.sv
// Top level of the eight-bit ALU: input register, datapath and result register.
//
// The unit takes one beat per clock cycle while its output is not stalled and
// returns one result beat for each. A beat is captured in the input register,
// passes the combinational ALU datapath and lands in the result register, where
// its result is offered on the output and is taken at an edge where out_tready
// is high. The input register can still take a beat while a finished result
// waits, as long as the input register is empty. in_tready falls only when both
// stages hold beats and out_tready is low. Throughput is one beat per cycle
// unless the output stalls, as the ALU datapath is combinational.
module eight_bit_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // acc_value[7:0], operand[15:8], bit_index[18:16],
                                  // flags_in[22:19], zero[23]
  input  logic [4:0]  in_tuser,   // operation[4:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result[7:0], flags_out[11:8], zero[15:12]
);

  logic            in_valid_r;
  logic            in_valid_nxt;
  ebalu_pkg::req_t in_req_r;
  ebalu_pkg::req_t in_req_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  ebalu_pkg::rsp_t out_rsp_r;
  ebalu_pkg::rsp_t exec_rsp;
  logic            out_load;
  logic            in_load;

  // The result stage can load whenever it is empty or being drained this cycle.
  assign out_load  = ~out_valid_r | out_tready;
  assign in_tready = ~in_valid_r | out_load;
  assign in_load   = in_tvalid & in_tready;

  always_comb begin
    in_req_nxt.operation = in_tuser;
    in_req_nxt.acc_value = in_tdata[7:0];
    in_req_nxt.operand   = in_tdata[15:8];
    in_req_nxt.bit_index = in_tdata[18:16];
    in_req_nxt.flags_in  = in_tdata[22:19];
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_req_r <= in_req_nxt;
    end
    if (out_load && in_valid_r) begin
      out_rsp_r <= exec_rsp;
    end
  end

  ebalu_exec u_exec (
    .req (in_req_r),
    .rsp (exec_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_rsp_r.flags_out, out_rsp_r.result};

endmodule

>>> rtl/core/ebalu_exec.sv
// Single-pass datapath: computes the result byte and new flags for one operation.
module ebalu_exec (
  input  ebalu_pkg::req_t req,
  output ebalu_pkg::rsp_t rsp
);

  ebalu_pkg::byte_t  a;
  ebalu_pkg::byte_t  b;
  ebalu_pkg::flags_t f;
  logic              cin;
  logic              zf;
  logic              nf;
  logic              hf;
  logic              ci;
  logic [8:0]        add_full;
  logic [4:0]        add_half;
  logic [8:0]        sub_full;
  logic [4:0]        sub_half;
  ebalu_pkg::byte_t  bit_mask;
  logic              daa_hi;
  logic              daa_lo;
  ebalu_pkg::byte_t  daa_adj;
  ebalu_pkg::byte_t  daa_res;
  logic              daa_c;
  ebalu_pkg::byte_t  r;
  logic              z_new;
  logic              n_new;
  logic              h_new;
  logic              c_new;
  logic              use_res_z;

  assign a   = req.acc_value;
  assign b   = req.operand;
  assign f   = req.flags_in;
  assign cin = f[ebalu_pkg::FlagC];
  assign zf  = f[ebalu_pkg::FlagZ];
  assign nf  = f[ebalu_pkg::FlagN];
  assign hf  = f[ebalu_pkg::FlagH];

  // Carry-in is only used by the with-carry forms.
  assign ci = ((req.operation == ebalu_pkg::OpAdc) || (req.operation == ebalu_pkg::OpSbc))
              ? cin : 1'b0;

  assign add_full = {1'b0, a} + {1'b0, b} + {8'd0, ci};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
  // The top bit of each difference is the borrow out of that width.
  assign sub_full = {1'b0, a} - {1'b0, b} - {8'd0, ci};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

  assign bit_mask = ebalu_pkg::byte_t'(1) << req.bit_index;

  // Decimal adjust: the correction depends on whether the last operation subtracted.
  assign daa_hi  = nf ? cin : (cin || (a > 8'h99));
  assign daa_lo  = nf ? hf  : (hf  || (a[3:0] > 4'h9));
  assign daa_adj = (daa_hi ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);
  assign daa_res = nf ? (a - daa_adj) : (a + daa_adj);
  assign daa_c   = daa_hi;

  always_comb begin
    r         = a;
    z_new     = zf;
    n_new     = nf;
    h_new     = hf;
    c_new     = cin;
    use_res_z = 1'b0;
    case (req.operation)
      ebalu_pkg::OpAdd, ebalu_pkg::OpAdc: begin
        r         = add_full[7:0];
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = add_half[4];
        c_new     = add_full[8];
      end
      ebalu_pkg::OpSub, ebalu_pkg::OpSbc, ebalu_pkg::OpCp: begin
        r         = (req.operation == ebalu_pkg::OpCp) ? a : sub_full[7:0];
        z_new     = (sub_full[7:0] == 8'h00);
        n_new     = 1'b1;
        h_new     = sub_half[4];
        c_new     = sub_full[8];
      end
      ebalu_pkg::OpAnd: begin
        r         = a & b;
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b1;
        c_new     = 1'b0;
      end
      ebalu_pkg::OpOr: begin
        r         = a | b;
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = 1'b0;
      end
      ebalu_pkg::OpXor: begin
        r         = a ^ b;
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = 1'b0;
      end
      ebalu_pkg::OpInc: begin
        r         = b + 8'd1;
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = (b[3:0] == 4'hF);
      end
      ebalu_pkg::OpDec: begin
        r         = b - 8'd1;
        use_res_z = 1'b1;
        n_new     = 1'b1;
        h_new     = (b[3:0] == 4'h0);
      end
      ebalu_pkg::OpRlca: begin
        r     = {a[6:0], a[7]};
        z_new = 1'b0;
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = a[7];
      end
      ebalu_pkg::OpRla: begin
        r     = {a[6:0], cin};
        z_new = 1'b0;
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = a[7];
      end
      ebalu_pkg::OpRrca: begin
        r     = {a[0], a[7:1]};
        z_new = 1'b0;
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = a[0];
      end
      ebalu_pkg::OpRra: begin
        r     = {cin, a[7:1]};
        z_new = 1'b0;
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = a[0];
      end
      ebalu_pkg::OpRlc: begin
        r         = {b[6:0], b[7]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[7];
      end
      ebalu_pkg::OpRl: begin
        r         = {b[6:0], cin};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[7];
      end
      ebalu_pkg::OpRrc: begin
        r         = {b[0], b[7:1]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[0];
      end
      ebalu_pkg::OpRr: begin
        r         = {cin, b[7:1]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[0];
      end
      ebalu_pkg::OpSla: begin
        r         = {b[6:0], 1'b0};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[7];
      end
      ebalu_pkg::OpSra: begin
        r         = {b[7], b[7:1]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[0];
      end
      ebalu_pkg::OpSrl: begin
        r         = {1'b0, b[7:1]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = b[0];
      end
      ebalu_pkg::OpSwap: begin
        r         = {b[3:0], b[7:4]};
        use_res_z = 1'b1;
        n_new     = 1'b0;
        h_new     = 1'b0;
        c_new     = 1'b0;
      end
      ebalu_pkg::OpBit: begin
        z_new = ~b[req.bit_index];
        n_new = 1'b0;
        h_new = 1'b1;
      end
      ebalu_pkg::OpSet: begin
        r = b | bit_mask;
      end
      ebalu_pkg::OpRes: begin
        r = b & ~bit_mask;
      end
      ebalu_pkg::OpDaa: begin
        r         = daa_res;
        use_res_z = 1'b1;
        h_new     = 1'b0;
        c_new     = daa_c;
      end
      ebalu_pkg::OpCpl: begin
        r     = ~a;
        n_new = 1'b1;
        h_new = 1'b1;
      end
      ebalu_pkg::OpCcf: begin
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = ~cin;
      end
      ebalu_pkg::OpScf: begin
        n_new = 1'b0;
        h_new = 1'b0;
        c_new = 1'b1;
      end
      default: begin
        // Unassigned codes leave the accumulator and flags as they were.
        r = a;
      end
    endcase
  end

  always_comb begin
    rsp.result                     = r;
    rsp.flags_out[ebalu_pkg::FlagZ] = use_res_z ? (r == 8'h00) : z_new;
    rsp.flags_out[ebalu_pkg::FlagN] = n_new;
    rsp.flags_out[ebalu_pkg::FlagH] = h_new;
    rsp.flags_out[ebalu_pkg::FlagC] = c_new;
  end

endmodule

>>> test/alu_flags_compare.sv
// Predicts each result beat of the eight-bit ALU and compares it with what the unit returns.
module alu_flags_compare
  import ebalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // acc_value[7:0], operand[15:8], bit_index[18:16],
                                  // flags_in[22:19], zero[23]
  input  logic [4:0]  in_tuser,   // operation[4:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // result[7:0], flags_out[11:8], zero[15:12]
  output int unsigned mismatches,
  output int unsigned pending
);

  rsp_t        expected_rsp_q[$];
  int unsigned err_total = 0;

  function automatic flags_t pack_flags(logic z, logic n, logic h, logic c);
    return {z, n, h, c};
  endfunction

  function automatic rsp_t alu_expect(req_t req);
    byte_t      a;
    byte_t      b;
    byte_t      r;
    byte_t      mask;
    flags_t     f;
    flags_t     fo;
    logic       ci;
    logic       cin;
    logic       c_daa;
    logic [8:0] wide;
    logic [4:0] nib;
    rsp_t       rsp;
    a    = req.acc_value;
    b    = req.operand;
    f    = req.flags_in;
    cin  = f[FlagC];
    mask = 8'h01 << req.bit_index;
    r    = a;
    fo   = f;
    case (req.operation)
      OpAdd, OpAdc: begin
        ci   = (req.operation == OpAdc) ? cin : 1'b0;
        wide = {1'b0, a} + {1'b0, b} + {8'd0, ci};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
        r    = wide[7:0];
        fo   = pack_flags(r == 8'h00, 1'b0, nib[4], wide[8]);
      end
      OpSub, OpSbc, OpCp: begin
        // Bit 8 and bit 4 of the widened differences are the full and half borrows.
        ci   = (req.operation == OpSbc) ? cin : 1'b0;
        wide = {1'b0, a} - {1'b0, b} - {8'd0, ci};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};
        fo   = pack_flags(wide[7:0] == 8'h00, 1'b1, nib[4], wide[8]);
        r    = (req.operation == OpCp) ? a : wide[7:0];
      end
      OpAnd: begin
        r  = a & b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OpOr: begin
        r  = a | b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OpXor: begin
        r  = a ^ b;
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OpInc: begin
        r  = b + 8'h01;
        fo = pack_flags(r == 8'h00, 1'b0, b[3:0] == 4'hF, cin);
      end
      OpDec: begin
        r  = b - 8'h01;
        fo = pack_flags(r == 8'h00, 1'b1, b[3:0] == 4'h0, cin);
      end
      OpRlca: begin
        r  = {a[6:0], a[7]};
        fo = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      OpRla: begin
        r  = {a[6:0], cin};
        fo = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
      end
      OpRrca: begin
        r  = {a[0], a[7:1]};
        fo = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      OpRra: begin
        r  = {cin, a[7:1]};
        fo = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
      end
      OpRlc: begin
        r  = {b[6:0], b[7]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[7]);
      end
      OpRl: begin
        r  = {b[6:0], cin};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[7]);
      end
      OpRrc: begin
        r  = {b[0], b[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[0]);
      end
      OpRr: begin
        r  = {cin, b[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[0]);
      end
      OpSla: begin
        r  = {b[6:0], 1'b0};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[7]);
      end
      OpSra: begin
        r  = {b[7], b[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[0]);
      end
      OpSrl: begin
        r  = {1'b0, b[7:1]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, b[0]);
      end
      OpSwap: begin
        r  = {b[3:0], b[7:4]};
        fo = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OpBit: begin
        fo = pack_flags((b & mask) == 8'h00, 1'b0, 1'b1, cin);
      end
      OpSet: r = b | mask;
      OpRes: r = b & ~mask;
      OpDaa: begin
        c_daa = cin;
        if (!f[FlagN]) begin
          if (cin || a > 8'h99) begin
            r     = r + 8'h60;
            c_daa = 1'b1;
          end
          if (f[FlagH] || a[3:0] > 4'h9) r = r + 8'h06;
        end else begin
          if (cin) r = r - 8'h60;
          if (f[FlagH]) r = r - 8'h06;
        end
        fo = pack_flags(r == 8'h00, f[FlagN], 1'b0, c_daa);
      end
      OpCpl: begin
        r  = ~a;
        fo = pack_flags(f[FlagZ], 1'b1, 1'b1, cin);
      end
      OpCcf: fo = pack_flags(f[FlagZ], 1'b0, 1'b0, ~cin);
      OpScf: fo = pack_flags(f[FlagZ], 1'b0, 1'b0, 1'b1);
      default: ;
    endcase
    rsp.result    = r;
    rsp.flags_out = fo;
    return rsp;
  endfunction

  always @(posedge clk) begin
    rsp_t  want;
    req_t  seen;
    byte_t got_result;
    flags_t got_flags;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_result = out_tdata[7:0];
        got_flags  = out_tdata[11:8];
        if (expected_rsp_q.size() == 0) begin
          $error("result beat %h arrived with no beat outstanding", out_tdata);
          err_total++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (got_result !== want.result) begin
            $error("result: expected %h, got %h", want.result, got_result);
            err_total++;
          end
          if (got_flags !== want.flags_out) begin
            $error("flags_out: expected %b, got %b", want.flags_out, got_flags);
            err_total++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen.operation = in_tuser;
        seen.acc_value = in_tdata[7:0];
        seen.operand   = in_tdata[15:8];
        seen.bit_index = in_tdata[18:16];
        seen.flags_in  = in_tdata[22:19];
        expected_rsp_q.push_back(alu_expect(seen));
      end
    end
    mismatches <= err_total;
    pending    <= expected_rsp_q.size();
  end

endmodule

>>> test/eight_bit_alu_with_flags_tb.sv
// Stimulus and verdict for the eight-bit ALU, with the result comparison beside the unit.
module eight_bit_alu_with_flags_tb;
  import ebalu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // acc_value[7:0], operand[15:8], bit_index[18:16],
                           // flags_in[22:19], zero[23]
  logic [4:0]  in_tuser;   // operation[4:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // result[7:0], flags_out[11:8], zero[15:12]
  int unsigned mismatches;
  int unsigned pending;

  eight_bit_alu_with_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alu_flags_compare u_compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100000;
    $display("FAIL");
    $finish;
  end

  // Result side: random stalls, then a long hold-off so that both stages fill and
  // in_tready falls, then a calm stretch, then random stalls again.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    repeat (300) @(negedge clk) out_tready <= ($urandom_range(99) >= 10);
    repeat (80) @(negedge clk) out_tready <= 1'b0;
    repeat (300) @(negedge clk) out_tready <= 1'b1;
    forever @(negedge clk) out_tready <= ($urandom_range(99) >= 10);
  end

  function automatic byte_t pick_byte();
    byte_t corner [8] = '{8'h00, 8'hFF, 8'h99, 8'h9A, 8'h0F, 8'h10, 8'h80, 8'h7F};
    if ($urandom_range(7) == 0) return corner[$urandom_range(7)];
    return byte_t'($urandom_range(255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_op(op_t op, byte_t a, byte_t b, logic [2:0] bi, flags_t f,
                          bit may_idle);
    int idle_len;
    if (may_idle && $urandom_range(99) < 5) begin
      idle_len = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (idle_len) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, f, bi, b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    op_t  op;
    bit   calm;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Every code including the unused ones, at the extremes of the data and flags.
    for (int k = 0; k < 32; k++) begin
      op = op_t'(k);
      offer_op(op, op[0] ? 8'hFF : 8'h00, op[1] ? 8'hFF : 8'h01, op[2:0],
               op[0] ? 4'hF : 4'h0, 1'b0);
    end
    // Decimal adjust after an addition and after a subtraction, a half carry, and a bit test.
    offer_op(OpDaa, 8'h9A, 8'h00, 3'd0, 4'h0, 1'b0);
    offer_op(OpDaa, 8'h00, 8'h00, 3'd0, 4'h7, 1'b0);
    offer_op(OpAdd, 8'h0F, 8'h01, 3'd7, 4'h0, 1'b0);
    offer_op(OpBit, 8'h55, 8'h7F, 3'd7, 4'h1, 1'b0);

    for (int n = 0; n < 850; n++) begin
      calm = (n >= 350 && n < 550);
      offer_op(op_t'($urandom_range(31)), pick_byte(), pick_byte(),
               3'($urandom_range(7)), 4'($urandom_range(15)), !calm);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ebalu_pkg.sv
rtl/core/ebalu_exec.sv
rtl/core/eight_bit_alu_with_flags.sv
test/alu_flags_compare.sv
test/eight_bit_alu_with_flags_tb.sv
